[hdl/csort_pkg.sv]
// ----------------------------------------------------------------------------
// csort_pkg
// Shared types, constants and helpers of the coincidence sorter: buffer
// geometry, register indexes, result kinds and the payload words.
// ----------------------------------------------------------------------------
package csort_pkg;

  // Buffer geometry
  localparam int BUF_DEPTH  = 16;
  localparam int PTR_W      = $clog2(BUF_DEPTH);
  localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
  localparam int RESULT_CAP = 16;
  localparam int RES_W      = $clog2(RESULT_CAP + 1);

  // Field widths
  localparam int TIME_W  = 48;
  localparam int ENER_W  = 16;
  localparam int DECAY_W = 32;
  localparam int SECT_W  = 10;
  localparam int MOD_W   = 8;
  localparam int CRYS_W  = 12;
  localparam int SCAT_W  = 8;
  localparam int KIND_W  = 3;
  localparam int WIN_W   = 20;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_MIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_MAX = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_MOD = CFG_IDX_W'(3);

  localparam logic [WIN_W-1:0]  WINDOW_RST     = WIN_W'(2000);
  localparam logic [ENER_W-1:0] ENERGY_MIN_RST = ENER_W'(4497);
  localparam logic [ENER_W-1:0] ENERGY_MAX_RST = ENER_W'(5723);
  localparam logic [SECT_W-1:0] SECTOR_MOD_RST = SECT_W'(40);

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_MULTI   = 3'd0,
    KIND_REJECT  = 3'd1,
    KIND_TRUE    = 3'd2,
    KIND_SCATTER = 3'd3,
    KIND_RANDOM  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [TIME_W-1:0]  event_time_ps;
    logic [ENER_W-1:0]  photon_energy;
    logic [DECAY_W-1:0] decay_id;
    logic [SECT_W-1:0]  sector_id;
    logic [MOD_W-1:0]   module_id;
    logic [CRYS_W-1:0]  crystal_id;
    logic [SCAT_W-1:0]  scatter_count;
  } in_word_t;

  typedef struct packed {
    kind_e              kind;
    logic [SECT_W-1:0]  first_sector;
    logic [MOD_W-1:0]   first_module;
    logic [CRYS_W-1:0]  first_crystal;
    logic [SECT_W-1:0]  second_sector;
    logic [MOD_W-1:0]   second_module;
    logic [CRYS_W-1:0]  second_crystal;
    logic               last;
  } out_word_t;

  // Crystal position of a held single
  typedef struct packed {
    logic [SECT_W-1:0] sector;
    logic [MOD_W-1:0]  modnum;
    logic [CRYS_W-1:0] crystal;
  } pos_t;

  // One buffer entry
  typedef struct packed {
    logic [TIME_W-1:0]  tstamp;
    logic [ENER_W-1:0]  energy;
    logic [DECAY_W-1:0] decay;
    pos_t               pos;
    logic [SCAT_W-1:0]  scatter;
  } ent_t;

  // Circular buffer pointer add with wrap
  function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] a, logic [PTR_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W+1)'(BUF_DEPTH)) s = s - (PTR_W+1)'(BUF_DEPTH);
    return s[PTR_W-1:0];
  endfunction

  // |x - y| < w, evaluated as two parallel add-and-compare paths
  function automatic logic win_hit(logic [TIME_W-1:0] x, logic [TIME_W-1:0] y,
                                   logic [WIN_W-1:0] w);
    logic [TIME_W:0] xw;
    logic [TIME_W:0] yw;
    xw = {1'b0, x} + (TIME_W+1)'(w);
    yw = {1'b0, y} + (TIME_W+1)'(w);
    return ({1'b0, y} < xw) && ({1'b0, x} < yw);
  endfunction

endpackage

[hdl/csort_rem.sv]
// ----------------------------------------------------------------------------
// csort_rem
// Iterative restoring remainder unit: sector number modulo a nonzero
// modulus, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module csort_rem import csort_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SECT_W-1:0] dividend_i,
  input  logic [SECT_W-1:0] divisor_i,
  output logic              done_o,
  output logic [SECT_W-1:0] rem_o
);

  localparam int STEP_W = $clog2(SECT_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SECT_W-1:0] acc_q, acc_d;
  logic [SECT_W-1:0] dvd_q, dvd_d;
  logic [SECT_W-1:0] dsr_q, dsr_d;
  logic [SECT_W:0]   trial;

  // Shift in one dividend bit, subtract the divisor when it fits
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    acc_d  = acc_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    trial  = {acc_q, dvd_q[SECT_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SECT_W - 1);
      acc_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        acc_d = SECT_W'(trial - {1'b0, dsr_q});
      end else begin
        acc_d = trial[SECT_W-1:0];
      end
      dvd_d = {dvd_q[SECT_W-2:0], 1'b0};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    acc_q  <= acc_d;
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = acc_q;

endmodule

[hdl/coincidence_sorter_unit.sv]
// ----------------------------------------------------------------------------
// coincidence_sorter_unit
// Coincidence sorter for time-ordered detector singles: buffers singles in a
// circular memory and settles the head group into multiples, rejected
// doubles and true, scatter or random coincidences.
//
//   channel  dir  handshake               word
//   in       in   in_valid_i/in_ready_o   in_word_i  (one single)
//   out      out  out_valid_o/out_ready_i out_word_o (one coincidence result)
//   cfg      in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A single is written to the buffer in its accept cycle; the sequencer then
// walks the head group through the single memory read port: it reads each head
// and the singles behind it, hands on each result and closes the group. A
// double with a nonzero modulus adds two passes of the remainder unit for
// sector ordering; with a zero modulus the sectors are compared directly.
// Result hand-off and the close wait only when the output word is still held
// by a stalled consumer. After reset the buffer is empty and no clearing pass
// is run; the block is ready at once.
// ----------------------------------------------------------------------------
module coincidence_sorter_unit import csort_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOOP  = 9'b000000010,
    S_RDH   = 9'b000000100,
    S_CMP1  = 9'b000001000,
    S_SCAN  = 9'b000010000,
    S_REM0  = 9'b000100000,
    S_REM1  = 9'b001000000,
    S_RES   = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PTR_W-1:0]  m_q, m_d;
  logic [RES_W-1:0]  nres_q, nres_d;
  ent_t              h_q, h_d;
  ent_t              b_q, b_d;
  logic [SECT_W-1:0] k0_q, k0_d;
  out_word_t         res_q, res_d;
  out_word_t         pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  out_word_t         out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic [WIN_W-1:0]  win_q;
  logic [ENER_W-1:0] emin_q;
  logic [ENER_W-1:0] emax_q;
  logic [SECT_W-1:0] smod_q;

  ent_t              mem_q [BUF_DEPTH];
  ent_t              rd_q;
  logic [PTR_W-1:0]  rd_rel;
  logic [PTR_W-1:0]  rd_addr;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  ent_t              wr_data;

  logic              rem_start;
  logic [SECT_W-1:0] rem_dvd;
  logic              rem_done;
  logic [SECT_W-1:0] rem_val;

  logic              out_free;
  logic              in_w;
  logic              full;
  logic [PTR_W-1:0]  head_acc;
  logic [CNT_W-1:0]  cnt_acc;
  logic              e0_ok, e1_ok;
  kind_e             pair_kind;
  logic              pair_load, pair_swap;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_vld_q || out_ready_i;
  assign in_w       = win_hit(h_q.tstamp, rd_q.tstamp, win_q);

  // Classify the head pair
  assign e0_ok = (h_q.energy > emin_q) && (h_q.energy < emax_q);
  assign e1_ok = (b_q.energy > emin_q) && (b_q.energy < emax_q);
  always_comb begin
    if ((h_q.pos.sector == b_q.pos.sector) || !e0_ok || !e1_ok) begin
      pair_kind = KIND_REJECT;
    end else if (h_q.decay == b_q.decay) begin
      pair_kind = (h_q.scatter == '0 && b_q.scatter == '0) ? KIND_TRUE : KIND_SCATTER;
    end else begin
      pair_kind = KIND_RANDOM;
    end
  end

  // Make room on a full buffer, then append at the tail
  assign full     = (cnt_q == CNT_W'(BUF_DEPTH));
  assign head_acc = full ? ptr_add(head_q, PTR_W'(1)) : head_q;
  assign cnt_acc  = full ? CNT_W'(BUF_DEPTH - 1) : cnt_q;
  assign wr_addr  = ptr_add(head_acc, cnt_acc[PTR_W-1:0]);
  assign wr_en    = in_valid_i && (state_q == S_IDLE);
  assign wr_data  = '{tstamp:  in_word_i.event_time_ps,
                      energy:  in_word_i.photon_energy,
                      decay:   in_word_i.decay_id,
                      pos:     '{sector:  in_word_i.sector_id,
                                 modnum:  in_word_i.module_id,
                                 crystal: in_word_i.crystal_id},
                      scatter: in_word_i.scatter_count};

  // Read address relative to the head
  always_comb begin
    case (state_q)
      S_LOOP:  rd_rel = '0;
      S_RDH:   rd_rel = PTR_W'(1);
      S_CMP1:  rd_rel = PTR_W'(2);
      S_SCAN:  rd_rel = m_q + PTR_W'(1);
      default: rd_rel = '0;
    endcase
  end
  assign rd_addr = ptr_add(head_q, rd_rel);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    m_d        = m_q;
    nres_d     = nres_q;
    h_d        = h_q;
    b_d        = b_q;
    k0_d       = k0_q;
    res_d      = res_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    rem_start  = 1'b0;
    rem_dvd    = h_q.pos.sector;
    pair_load  = 1'b0;
    pair_swap  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          head_d  = head_acc;
          cnt_d   = cnt_acc + CNT_W'(1);
          nres_d  = '0;
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (nres_q == RES_W'(RESULT_CAP) || cnt_q < CNT_W'(2)) begin
          state_d = S_FLUSH;
        end else begin
          state_d = S_RDH;
        end
      end
      S_RDH: begin
        h_d     = rd_q;
        state_d = S_CMP1;
      end
      S_CMP1: begin
        b_d = rd_q;
        if (!in_w) begin
          // drop the lone head
          head_d  = ptr_add(head_q, PTR_W'(1));
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_LOOP;
        end else if (cnt_q < CNT_W'(3)) begin
          state_d = S_FLUSH;
        end else begin
          m_d     = PTR_W'(2);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!in_w && m_q == PTR_W'(2)) begin
          // double: drop both, then order by sector remainder (by sector for a zero modulus)
          res_d      = '0;
          res_d.kind = pair_kind;
          head_d     = ptr_add(head_q, PTR_W'(2));
          cnt_d      = cnt_q - CNT_W'(2);
          if (smod_q == '0) begin
            pair_load = 1'b1;
            pair_swap = h_q.pos.sector > b_q.pos.sector;
            state_d   = S_RES;
          end else begin
            rem_start = 1'b1;
            state_d   = S_REM0;
          end
        end else if (!in_w) begin
          // multiple: keep the last in-window single
          res_d      = '0;
          res_d.kind = KIND_MULTI;
          head_d     = ptr_add(head_q, m_q - PTR_W'(1));
          cnt_d      = cnt_q - CNT_W'(m_q - PTR_W'(1));
          state_d    = S_RES;
        end else if ({1'b0, m_q} + (PTR_W+1)'(1) < (PTR_W+1)'(cnt_q)) begin
          m_d = m_q + PTR_W'(1);
        end else if (full) begin
          // group still open on a full buffer: force a multiple
          res_d      = '0;
          res_d.kind = KIND_MULTI;
          head_d     = ptr_add(head_q, PTR_W'(cnt_q - CNT_W'(1)));
          cnt_d      = CNT_W'(1);
          state_d    = S_RES;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_REM0: begin
        if (rem_done) begin
          k0_d      = rem_val;
          rem_start = 1'b1;
          rem_dvd   = b_q.pos.sector;
          state_d   = S_REM1;
        end
      end
      S_REM1: begin
        if (rem_done) begin
          pair_load = 1'b1;
          pair_swap = k0_q > rem_val;
          state_d   = S_RES;
        end
      end
      S_RES: begin
        // hand the previous result on, hold the new one until the next decision
        if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_d      = pend_q;
            out_d.last = 1'b0;
            out_vld_d  = 1'b1;
          end
          pend_d     = res_q;
          pend_vld_d = 1'b1;
          nres_d     = nres_q + RES_W'(1);
          state_d    = S_LOOP;
        end
      end
      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Fill pair positions in sorted order
    if (pair_load) begin
      if (pair_swap) begin
        res_d.first_sector   = b_q.pos.sector;
        res_d.first_module   = b_q.pos.modnum;
        res_d.first_crystal  = b_q.pos.crystal;
        res_d.second_sector  = h_q.pos.sector;
        res_d.second_module  = h_q.pos.modnum;
        res_d.second_crystal = h_q.pos.crystal;
      end else begin
        res_d.first_sector   = h_q.pos.sector;
        res_d.first_module   = h_q.pos.modnum;
        res_d.first_crystal  = h_q.pos.crystal;
        res_d.second_sector  = b_q.pos.sector;
        res_d.second_module  = b_q.pos.modnum;
        res_d.second_crystal = b_q.pos.crystal;
      end
    end
  end

  // Sector remainder unit
  csort_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dvd),
    .divisor_i  (smod_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // Buffer memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      cnt_q      <= '0;
      nres_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      nres_q     <= nres_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    h_q    <= h_d;
    b_q    <= b_d;
    k0_q   <= k0_d;
    res_q  <= res_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= WINDOW_RST;
      emin_q <= ENERGY_MIN_RST;
      emax_q <= ENERGY_MAX_RST;
      smod_q <= SECTOR_MOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW:     win_q  <= cfg_wdata_i[WIN_W-1:0];
        CFG_ENERGY_MIN: emin_q <= cfg_wdata_i[ENER_W-1:0];
        CFG_ENERGY_MAX: emax_q <= cfg_wdata_i[ENER_W-1:0];
        CFG_SECTOR_MOD: smod_q <= cfg_wdata_i[SECT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule
